// ===== rtl/wsenc_pkg.sv =====
// Shared types and constants for the WS2812 line encoder.
// Used by every module of the block; depends on nothing.
package wsenc_pkg;

    localparam int unsigned MaxPixelsDefault = 8;
    localparam int unsigned CmdDepth         = 4;
    localparam int unsigned CfgIndexW        = 3;
    localparam int unsigned CfgDataW         = 16;

    localparam logic [CfgIndexW-1:0] RegOneHigh  = 3'd0;
    localparam logic [CfgIndexW-1:0] RegOneLow   = 3'd1;
    localparam logic [CfgIndexW-1:0] RegZeroHigh = 3'd2;
    localparam logic [CfgIndexW-1:0] RegZeroLow  = 3'd3;
    localparam logic [CfgIndexW-1:0] RegResetLow = 3'd4;

    localparam logic [7:0]  OneHighReset  = 8'd50;
    localparam logic [7:0]  OneLowReset   = 8'd50;
    localparam logic [7:0]  ZeroHighReset = 8'd18;
    localparam logic [7:0]  ZeroLowReset  = 8'd70;
    localparam logic [15:0] ResetLowReset = 16'd3600;

    // Timing registers as seen by the segment sequencer
    typedef struct packed {
        logic [7:0]  one_high;
        logic [7:0]  one_low;
        logic [7:0]  zero_high;
        logic [7:0]  zero_low;
        logic [15:0] reset_low;
    } wsenc_timing_t;

    // One classified request handed from front to back
    typedef struct packed {
        logic [7:0] color;
        logic       line;
        logic       send_bits;
        logic       send_end;
    } wsenc_cmd_t;

endpackage

// ===== rtl/wsenc_front.sv =====
// Front end: accepts color bytes, tracks the frame byte count and classifies
// each request into a command for the back end. Depends on wsenc_pkg.
module wsenc_front #(
    parameter int unsigned MAX_PIXELS = wsenc_pkg::MaxPixelsDefault
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             color_byte,
    input  logic                   strip_select,
    input  logic                   frame_end,
    output logic                   cmd_write,
    output wsenc_pkg::wsenc_cmd_t  cmd
);
    import wsenc_pkg::*;

    localparam int unsigned FrameLimit = MAX_PIXELS * 3;
    localparam int unsigned CntW       = $clog2(FrameLimit + 1);

    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            below_limit;

    always_comb
    begin
        below_limit   = count_reg < CntW'(FrameLimit);
        cmd.color     = color_byte;
        cmd.line      = strip_select;
        cmd.send_bits = below_limit;
        cmd.send_end  = frame_end;
        // drop requests that give no segment at all
        cmd_write     = accept && (below_limit || frame_end);
        count_next    = count_reg;
        if (accept)
        begin
            if (frame_end)
                count_next = '0;
            else if (below_limit)
                count_next = count_reg + CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

// ===== rtl/wsenc_cmd_fifo.sv =====
// Short command queue between the front end and the segment sequencer.
// Depends on wsenc_pkg for the command type and depth.
module wsenc_cmd_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr,
    input  wsenc_pkg::wsenc_cmd_t  wr_cmd,
    input  logic                   rd,
    output wsenc_pkg::wsenc_cmd_t  rd_cmd,
    output logic                   full,
    output logic                   empty
);
    import wsenc_pkg::*;

    localparam int unsigned PtrW = $clog2(CmdDepth);
    localparam int unsigned CntW = $clog2(CmdDepth + 1);

    wsenc_cmd_t      slot_reg [CmdDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_wr;
    logic            do_rd;

    assign full   = count_reg == CntW'(CmdDepth);
    assign empty  = count_reg == '0;
    assign do_wr  = wr && !full;
    assign do_rd  = rd && !empty;
    assign rd_cmd = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + PtrW'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CntW'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CntW'(1);
        end
    end

endmodule

// ===== rtl/wsenc_back.sv =====
// Back end: steps each command's sixteen bit segments and/or latch segment,
// one per cycle while pop is held, into an output register. Uses wsenc_pkg.
module wsenc_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  wsenc_pkg::wsenc_timing_t timing,
    input  wsenc_pkg::wsenc_cmd_t    cmd,
    input  logic                     cmd_empty,
    output logic                     cmd_pop,
    input  logic                     pop,
    output logic                     empty,
    output logic                     line_level,
    output logic [15:0]              segment_cycles,
    output logic                     line_select,
    output logic                     last_segment
);
    import wsenc_pkg::*;

    logic [4:0]  seg_idx_reg;
    logic [4:0]  seg_idx_next;
    logic        out_valid_reg;
    logic        level_reg;
    logic [15:0] cycles_reg;
    logic        line_reg;
    logic        last_reg;

    logic        seg_reset;
    logic        bit_one;
    logic        seg_level;
    logic [7:0]  bit_time;
    logic [15:0] raw_cycles;
    logic [15:0] seg_cycles;
    logic        seg_last;
    logic        load;

    always_comb
    begin
        seg_reset  = !cmd.send_bits || seg_idx_reg[4];
        bit_one    = cmd.color[~seg_idx_reg[3:1]];
        seg_level  = !seg_reset && !seg_idx_reg[0];
        if (seg_idx_reg[0])
            bit_time = bit_one ? timing.one_low : timing.zero_low;
        else
            bit_time = bit_one ? timing.one_high : timing.zero_high;
        raw_cycles = seg_reset ? timing.reset_low : {8'd0, bit_time};
        // a zero-length setting is replaced by the smallest nonzero length
        seg_cycles = (raw_cycles == 16'd0) ? 16'd1 : raw_cycles;
        seg_last   = seg_reset || (seg_idx_reg[3:0] == 4'hF && !cmd.send_end);
        load       = !cmd_empty && (!out_valid_reg || pop);
        cmd_pop    = load && seg_last;
        seg_idx_next = seg_idx_reg;
        if (load)
            seg_idx_next = seg_last ? 5'd0 : seg_idx_reg + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seg_idx_reg   <= seg_idx_next;
            out_valid_reg <= load || (out_valid_reg && !pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            level_reg  <= seg_level;
            cycles_reg <= seg_cycles;
            line_reg   <= cmd.line;
            last_reg   <= seg_last;
        end
    end

    assign empty          = !out_valid_reg;
    assign line_level     = level_reg;
    assign segment_cycles = cycles_reg;
    assign line_select    = line_reg;
    assign last_segment   = last_reg;

endmodule

// ===== rtl/ws2812_line_encoder.sv =====
// WS2812 line encoder top level: timing registers, front end, command queue
// and segment sequencer. Depends on wsenc_pkg and the wsenc_* modules.
//
//   Channel   Handshake          Payload
//   input     push / full        color_byte, strip_select, frame_end
//   result    empty / pop        line_level, segment_cycles, line_select, last_segment
//   config    cfg_we             cfg_index, cfg_data
//
// A byte within the frame limit yields sixteen segments, one per cycle when
// pop is held; a frame end adds one latch segment. The sequencer emits one
// segment a cycle while pop is held; the command queue lets new bytes in
// while segments of earlier bytes are still going out. Reset clears the
// frame count and queue, empties the output register, loads default timings.
module ws2812_line_encoder #(
    parameter int unsigned MAX_PIXELS = wsenc_pkg::MaxPixelsDefault
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       color_byte,
    input  logic                             strip_select,
    input  logic                             frame_end,
    output logic                             empty,
    input  logic                             pop,
    output logic                             line_level,
    output logic [15:0]                      segment_cycles,
    output logic                             line_select,
    output logic                             last_segment,
    input  logic                             cfg_we,
    input  logic [wsenc_pkg::CfgIndexW-1:0]  cfg_index,
    input  logic [wsenc_pkg::CfgDataW-1:0]   cfg_data
);
    import wsenc_pkg::*;

    wsenc_timing_t timing_reg;
    wsenc_cmd_t    front_cmd;
    wsenc_cmd_t    head_cmd;
    logic          front_write;
    logic          cmd_empty;
    logic          cmd_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.one_high  <= OneHighReset;
            timing_reg.one_low   <= OneLowReset;
            timing_reg.zero_high <= ZeroHighReset;
            timing_reg.zero_low  <= ZeroLowReset;
            timing_reg.reset_low <= ResetLowReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegOneHigh:  timing_reg.one_high  <= cfg_data[7:0];
                RegOneLow:   timing_reg.one_low   <= cfg_data[7:0];
                RegZeroHigh: timing_reg.zero_high <= cfg_data[7:0];
                RegZeroLow:  timing_reg.zero_low  <= cfg_data[7:0];
                RegResetLow: timing_reg.reset_low <= cfg_data;
                default: ;
            endcase
        end
    end

    wsenc_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (push && !full),
        .color_byte   (color_byte),
        .strip_select (strip_select),
        .frame_end    (frame_end),
        .cmd_write    (front_write),
        .cmd          (front_cmd)
    );

    wsenc_cmd_fifo u_cmd_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (front_write),
        .wr_cmd (front_cmd),
        .rd     (cmd_pop),
        .rd_cmd (head_cmd),
        .full   (full),
        .empty  (cmd_empty)
    );

    wsenc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .timing         (timing_reg),
        .cmd            (head_cmd),
        .cmd_empty      (cmd_empty),
        .cmd_pop        (cmd_pop),
        .pop            (pop),
        .empty          (empty),
        .line_level     (line_level),
        .segment_cycles (segment_cycles),
        .line_select    (line_select),
        .last_segment   (last_segment)
    );

endmodule
